// File: rtl/core/acir_pkg.sv
// Shared types, constants and the command packing function of the IR frame encoder.
`default_nettype none

package acir_pkg;

    localparam int unsigned CODE_BITS = 34;

    localparam logic [4:0] TEMP_OFFSET = 5'd15;
    localparam logic [1:0] LEAD_LAST   = 2'd2;   // lead mark and lead space are 3 units each
    localparam logic [1:0] CLOSE_LAST  = 2'd3;   // closing mark is 4 units
    localparam logic [1:0] COPY_LAST   = 2'd2;   // the frame is sent 3 times
    localparam logic [5:0] BIT_MSB     = 6'(CODE_BITS - 1);

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    typedef enum logic [4:0] {
        SEG_IDLE       = 5'b00001,
        SEG_LEAD_MARK  = 5'b00010,
        SEG_LEAD_SPACE = 5'b00100,
        SEG_DATA       = 5'b01000,
        SEG_CLOSE      = 5'b10000
    } t_seg;

    typedef struct packed {
        logic       req_type;
        logic       power_toggle;
        logic [2:0] op_mode;
        logic [1:0] fan_speed;
        logic [4:0] temp_celsius;
        logic       swing_on;
        logic       sleep_on;
        logic       ifeel_on;
    } t_req;

    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic frame_last;
    } t_res;

    function automatic logic [CODE_BITS-1:0] pack_code(input t_req req);
        logic [CODE_BITS-1:0] code;
        code        = '0;
        code[33]    = req.power_toggle;
        code[32:30] = req.op_mode;
        code[29:28] = req.fan_speed;
        code[25]    = req.swing_on;
        code[24]    = req.ifeel_on;
        code[23:19] = req.temp_celsius - TEMP_OFFSET;
        code[18]    = req.sleep_on;
        code[1]     = 1'b1;
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/acir_if.sv
// Valid/ready channel interfaces for the request and result transactions.
`default_nettype none

interface acir_req_if;
    logic          valid;
    logic          ready;
    acir_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface acir_res_if;
    logic          valid;
    logic          ready;
    acir_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ac_ir_manchester_frame_encoder_top.sv
// Top level of the air-conditioner IR frame encoder: command packing and envelope sequencer.
`default_nettype none

// The block accepts one request transaction per clock. A send request packs the
// command into a 34-bit code and arms the sequencer when it is idle; it is dropped
// while a frame is in flight and never produces a result. Each tick request stands
// for one 1 ms unit and produces exactly one result transaction carrying the IR
// envelope level for that unit, a busy flag and a flag on the very last unit.
// The transmission is three copies of: 3 units mark, 3 units space, 34 Manchester
// bits MSB first (0 = mark then space, 1 = space then mark), followed by a single
// 4-unit closing mark, 226 ticks in all. Throughput is one transaction per clock;
// a request passes through the input register and then the result register, and
// the sequencer state is updated between the two in a single pass.
// The result register lets a new request enter while an earlier result still
// waits for the sink; only a full result register with the sink stalled holds the
// pipeline. Carrier modulation is not part of this block.
module ac_ir_manchester_frame_encoder_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    acir_req_if.sink   i_req,
    acir_res_if.source o_res
);

    // Input register.
    logic           r_in_valid;
    acir_pkg::t_req r_in_data;

    // Result register.
    logic           r_out_valid;
    logic           n_out_valid;
    acir_pkg::t_res r_out_data;
    acir_pkg::t_res n_out_data;

    // Sequencer state.
    acir_pkg::t_seg                   r_seg,        n_seg;
    logic [acir_pkg::CODE_BITS-1:0]   r_code_word,  n_code_word;
    logic [1:0]                       r_unit_count, n_unit_count;
    logic [5:0]                       r_bit_index,  n_bit_index;
    logic                             r_half_bit,   n_half_bit;
    logic [1:0]                       r_repeat,     n_repeat;

    // The stage advances whenever the result register is free or being drained.
    logic w_adv;
    logic w_proc;
    logic w_bit;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign w_proc      = r_in_valid && w_adv;
    assign i_req.ready = !r_in_valid || w_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    assign w_bit = r_code_word[r_bit_index];

    always_comb begin
        n_seg        = r_seg;
        n_code_word  = r_code_word;
        n_unit_count = r_unit_count;
        n_bit_index  = r_bit_index;
        n_half_bit   = r_half_bit;
        n_repeat     = r_repeat;
        n_out_valid  = w_adv ? 1'b0 : r_out_valid;
        n_out_data   = r_out_data;

        if (w_proc) begin
            if (r_in_data.req_type == acir_pkg::REQ_SEND) begin
                // A send request only arms an idle sequencer.
                if (r_seg == acir_pkg::SEG_IDLE) begin
                    n_code_word  = acir_pkg::pack_code(r_in_data);
                    n_seg        = acir_pkg::SEG_LEAD_MARK;
                    n_unit_count = 2'd0;
                    n_bit_index  = 6'd0;
                    n_half_bit   = 1'b0;
                    n_repeat     = 2'd0;
                end
            end else begin
                n_out_valid           = 1'b1;
                n_out_data.ir_level   = 1'b0;
                n_out_data.busy_res   = 1'b1;
                n_out_data.frame_last = 1'b0;
                case (r_seg)
                    acir_pkg::SEG_LEAD_MARK: begin
                        n_out_data.ir_level = 1'b1;
                        if (r_unit_count >= acir_pkg::LEAD_LAST) begin
                            n_seg        = acir_pkg::SEG_LEAD_SPACE;
                            n_unit_count = 2'd0;
                        end else begin
                            n_unit_count = r_unit_count + 2'd1;
                        end
                    end
                    acir_pkg::SEG_LEAD_SPACE: begin
                        if (r_unit_count >= acir_pkg::LEAD_LAST) begin
                            n_seg        = acir_pkg::SEG_DATA;
                            n_unit_count = 2'd0;
                            n_bit_index  = acir_pkg::BIT_MSB;
                            n_half_bit   = 1'b0;
                        end else begin
                            n_unit_count = r_unit_count + 2'd1;
                        end
                    end
                    acir_pkg::SEG_DATA: begin
                        // First half carries the inverted bit, second half the bit.
                        n_out_data.ir_level = r_half_bit ? w_bit : !w_bit;
                        if (!r_half_bit) begin
                            n_half_bit = 1'b1;
                        end else begin
                            n_half_bit = 1'b0;
                            if (r_bit_index == 6'd0) begin
                                n_unit_count = 2'd0;
                                if (r_repeat >= acir_pkg::COPY_LAST) begin
                                    n_seg = acir_pkg::SEG_CLOSE;
                                end else begin
                                    n_repeat = r_repeat + 2'd1;
                                    n_seg    = acir_pkg::SEG_LEAD_MARK;
                                end
                            end else begin
                                n_bit_index = r_bit_index - 6'd1;
                            end
                        end
                    end
                    acir_pkg::SEG_CLOSE: begin
                        n_out_data.ir_level = 1'b1;
                        if (r_unit_count >= acir_pkg::CLOSE_LAST) begin
                            n_out_data.frame_last = 1'b1;
                            n_seg                 = acir_pkg::SEG_IDLE;
                            n_unit_count          = 2'd0;
                            n_repeat              = 2'd0;
                        end else begin
                            n_unit_count = r_unit_count + 2'd1;
                        end
                    end
                    default: begin
                        // Idle tick: quiet line, not busy.
                        n_seg               = acir_pkg::SEG_IDLE;
                        n_out_data.busy_res = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_seg        <= acir_pkg::SEG_IDLE;
            r_code_word  <= '0;
            r_unit_count <= 2'd0;
            r_bit_index  <= 6'd0;
            r_half_bit   <= 1'b0;
            r_repeat     <= 2'd0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            r_out_valid  <= n_out_valid;
            r_seg        <= n_seg;
            r_code_word  <= n_code_word;
            r_unit_count <= n_unit_count;
            r_bit_index  <= n_bit_index;
            r_half_bit   <= n_half_bit;
            r_repeat     <= n_repeat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_data <= i_req.data;
        end
        r_out_data <= n_out_data;
    end

`ifndef SYNTH
    // The closing flag only ever rides on a busy mark unit.
    a_last_is_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.frame_last) |-> (r_out_data.ir_level && r_out_data.busy_res))
        else $error("frame_last on a unit that is not a busy mark");

    // An idle unit never drives the line.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.busy_res) |-> !r_out_data.ir_level)
        else $error("mark emitted while not busy");

    // The bit pointer never leaves the code word.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= acir_pkg::BIT_MSB)
        else $error("bit index beyond code word");

    // The copy counter stops at the last copy and is cleared back in idle.
    a_repeat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_repeat <= acir_pkg::COPY_LAST) &&
        ((r_seg != acir_pkg::SEG_IDLE) || (r_repeat == 2'd0 && r_unit_count == 2'd0)))
        else $error("copy or unit counter inconsistent");

    // Leaving the closing mark always comes with the last-unit flag.
    a_close_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_seg) == acir_pkg::SEG_CLOSE && r_seg == acir_pkg::SEG_IDLE) |->
        (r_out_valid && r_out_data.frame_last))
        else $error("closing mark ended without frame_last");
`endif

endmodule

`default_nettype wire
